// ----- hw/rtl/bfse_pkg.sv -----
// Shared types, constants and slot tables of the boiler frame sync extractor.
package bfse_pkg;

	localparam int FRAME_LENGTH = 512;
	localparam int CNT_W = 10;
	localparam int NUM_SLOTS = 15;
	localparam int SLOT_W = 4;
	localparam int NUM_RESULTS = 14;
	localparam int ID_W = 4;

	// configuration register indexes
	localparam logic [1:0] REG_HEADER_FIRST = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] REG_HEADER_THIRD = 2'd2;

	// slot roles used by the readout
	localparam logic [SLOT_W-1:0] SLOT_FALLBACK = 4'd2;
	localparam logic [ID_W-1:0] ID_RETURN = 4'd2;
	localparam logic [ID_W-1:0] ID_LAST = 4'd13;

	localparam logic [31:0] FLT_EXP_MASK = 32'h7F80_0000;
	localparam logic [31:0] FLT_POS_200 = 32'h4348_0000;
	localparam logic [30:0] FLT_MAG_50 = 31'h4248_0000;

	typedef struct packed {
		logic en;
		logic [SLOT_W-1:0] addr;
		logic [1:0] lane;
		logic [7:0] data;
	} cap_wr_t;

	typedef struct packed {
		logic hit;
		logic [SLOT_W-1:0] slot;
		logic [1:0] lane;
	} slot_hit_t;

	function automatic logic [CNT_W-1:0] slot_start(input logic [SLOT_W-1:0] s);
		case (s)
			4'd0: slot_start = 10'd86;
			4'd1: slot_start = 10'd90;
			4'd2: slot_start = 10'd94;
			4'd3: slot_start = 10'd106;
			4'd4: slot_start = 10'd118;
			4'd5: slot_start = 10'd234;
			4'd6: slot_start = 10'd250;
			4'd7: slot_start = 10'd279;
			4'd8: slot_start = 10'd294;
			4'd9: slot_start = 10'd296;
			4'd10: slot_start = 10'd298;
			4'd11: slot_start = 10'd300;
			4'd12: slot_start = 10'd302;
			4'd13: slot_start = 10'd306;
			4'd14: slot_start = 10'd310;
			default: slot_start = '1;
		endcase
	endfunction

	function automatic logic [2:0] slot_len(input logic [SLOT_W-1:0] s);
		case (s)
			4'd7: slot_len = 3'd1;
			4'd8, 4'd9, 4'd10, 4'd11, 4'd13, 4'd14: slot_len = 3'd2;
			default: slot_len = 3'd4;
		endcase
	endfunction

	function automatic logic [31:0] slot_mask(input logic [SLOT_W-1:0] s);
		case (slot_len(s))
			3'd1: slot_mask = 32'h0000_00FF;
			3'd2: slot_mask = 32'h0000_FFFF;
			default: slot_mask = 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [SLOT_W-1:0] result_slot(input logic [ID_W-1:0] k);
		case (k)
			4'd0: result_slot = 4'd0;
			4'd1: result_slot = 4'd1;
			4'd2: result_slot = 4'd3;
			4'd3: result_slot = 4'd4;
			4'd4: result_slot = 4'd5;
			4'd5: result_slot = 4'd7;
			4'd6: result_slot = 4'd6;
			4'd7: result_slot = 4'd8;
			4'd8: result_slot = 4'd9;
			4'd9: result_slot = 4'd10;
			4'd10: result_slot = 4'd11;
			4'd11: result_slot = 4'd12;
			4'd12: result_slot = 4'd13;
			4'd13: result_slot = 4'd14;
			default: result_slot = 4'd0;
		endcase
	endfunction

	// slots never overlap, so at most one compare hits
	function automatic slot_hit_t slot_decode(input logic [CNT_W-1:0] pos);
		slot_hit_t r;
		logic [CNT_W-1:0] st;
		logic [CNT_W-1:0] off;
		r = '0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			st = slot_start(SLOT_W'(s));
			off = pos - st;
			if (pos >= st && off < CNT_W'(slot_len(SLOT_W'(s)))) begin
				r.hit = 1'b1;
				r.slot = SLOT_W'(s);
				r.lane = off[1:0];
			end
		end
		return r;
	endfunction

	function automatic logic is_nan_or_inf(input logic [31:0] w);
		return (w & FLT_EXP_MASK) == FLT_EXP_MASK;
	endfunction

	function automatic logic in_fallback_range(input logic [31:0] w);
		if (is_nan_or_inf(w))
			return 1'b0;
		if (w[31])
			return w[30:0] < FLT_MAG_50;
		return w < FLT_POS_200;
	endfunction

endpackage

// ----- hw/rtl/bfse_capture_ram.sv -----
// Byte-lane writable capture memory holding the frame words, registered read.
module bfse_capture_ram (
	input  logic clk,
	input  bfse_pkg::cap_wr_t wr,
	input  logic [bfse_pkg::SLOT_W-1:0] rd_addr,
	output logic [31:0] rd_data
);

	logic [3:0][7:0] mem [bfse_pkg::NUM_SLOTS];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr][wr.lane] <= wr.data;
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/bfse_sync.sv -----
// Header hunt, frame byte counter, slot decode and header registers.
module bfse_sync (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] rx_byte,
	input  logic busy,
	output bfse_pkg::cap_wr_t wr,
	output logic frame_done
);

	typedef enum logic [1:0] {
		P_HUNT,
		P_SECOND,
		P_THIRD,
		P_FRAME
	} phase_t;

	phase_t phase_q;
	logic [bfse_pkg::CNT_W-1:0] count_q;
	logic [7:0] hdr_first_q;
	logic [7:0] hdr_second_q;
	logic [7:0] hdr_third_q;
	logic accept;
	logic last_byte;
	bfse_pkg::slot_hit_t dec;

	assign in_ready = !busy;
	assign accept = in_valid && in_ready;
	assign last_byte = count_q == bfse_pkg::CNT_W'(bfse_pkg::FRAME_LENGTH - 1);
	assign dec = bfse_pkg::slot_decode(count_q);
	assign frame_done = accept && phase_q == P_FRAME && last_byte;

	assign wr.en = accept && phase_q == P_FRAME && dec.hit;
	assign wr.addr = dec.slot;
	assign wr.lane = dec.lane;
	assign wr.data = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_HUNT;
			count_q <= '0;
			hdr_first_q <= '0;
			hdr_second_q <= '0;
			hdr_third_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					bfse_pkg::REG_HEADER_FIRST: hdr_first_q <= cfg_data;
					bfse_pkg::REG_HEADER_SECOND: hdr_second_q <= cfg_data;
					bfse_pkg::REG_HEADER_THIRD: hdr_third_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				case (phase_q)
					P_HUNT: begin
						if (rx_byte == hdr_first_q) begin
							phase_q <= P_SECOND;
							count_q <= bfse_pkg::CNT_W'(1);
						end
					end
					// failed byte is not retried as a first header byte
					P_SECOND: begin
						if (rx_byte == hdr_second_q) begin
							phase_q <= P_THIRD;
							count_q <= bfse_pkg::CNT_W'(2);
						end else begin
							phase_q <= P_HUNT;
							count_q <= '0;
						end
					end
					P_THIRD: begin
						if (rx_byte == hdr_third_q) begin
							phase_q <= P_FRAME;
							count_q <= bfse_pkg::CNT_W'(3);
						end else begin
							phase_q <= P_HUNT;
							count_q <= '0;
						end
					end
					default: begin
						if (last_byte) begin
							phase_q <= P_HUNT;
							count_q <= '0;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_hunt_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == P_HUNT |-> count_q == '0)
		else $error("count not zero while hunting");
	a_wr_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> phase_q == P_FRAME && count_q >= bfse_pkg::CNT_W'(3))
		else $error("capture write outside frame body");
	a_done_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> phase_q == P_HUNT && count_q == '0)
		else $error("no return to hunt after frame end");
`endif

endmodule

// ----- hw/rtl/bfse_readout.sv -----
// Frame-end readout sequencer: fallback check, word reads and result register.
module bfse_readout (
	input  logic clk,
	input  logic arst_n,
	input  logic frame_done,
	output logic busy,
	output logic [bfse_pkg::SLOT_W-1:0] rd_addr,
	input  logic [31:0] rd_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [bfse_pkg::ID_W-1:0] field_id,
	output logic [31:0] field_value,
	output logic last_field
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FB_RD,
		S_FB_LD,
		S_RD,
		S_LD,
		S_OUT
	} rstate_t;

	rstate_t state_q;
	logic [bfse_pkg::ID_W-1:0] idx_q;
	logic fb_ok_q;
	logic [31:0] fb_word_q;
	logic [31:0] value_q;
	logic [bfse_pkg::SLOT_W-1:0] cur_slot;
	logic [31:0] masked;
	logic [31:0] sel_value;

	assign cur_slot = bfse_pkg::result_slot(idx_q);
	assign rd_addr = (state_q == S_FB_RD) ? bfse_pkg::SLOT_FALLBACK : cur_slot;
	assign masked = rd_data & bfse_pkg::slot_mask(cur_slot);

	// return temperature falls back to offset 94 only on NaN/inf at 106
	always_comb begin
		sel_value = masked;
		if (idx_q == bfse_pkg::ID_RETURN && bfse_pkg::is_nan_or_inf(masked) && fb_ok_q)
			sel_value = fb_word_q;
	end

	assign busy = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign field_id = idx_q;
	assign field_value = value_q;
	assign last_field = idx_q == bfse_pkg::ID_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			fb_ok_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (frame_done) begin
						state_q <= S_FB_RD;
						idx_q <= '0;
					end
				end
				S_FB_RD: state_q <= S_FB_LD;
				S_FB_LD: begin
					fb_ok_q <= bfse_pkg::in_fallback_range(rd_data);
					state_q <= S_RD;
				end
				S_RD: state_q <= S_LD;
				S_LD: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) begin
						if (idx_q == bfse_pkg::ID_LAST) begin
							state_q <= S_IDLE;
							idx_q <= '0;
						end else begin
							state_q <= S_RD;
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FB_LD)
			fb_word_q <= rd_data;
		if (state_q == S_LD)
			value_q <= sel_value;
	end

`ifndef SYNTHESIS
	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |-> state_q == S_IDLE)
		else $error("frame end while readout busy");
	a_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_field) |-> field_id == bfse_pkg::ID_LAST)
		else $error("last flag on wrong field");
	a_ld_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LD |-> $past(state_q) == S_RD)
		else $error("result loaded without a read");
	a_final_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_field) |=> state_q == S_IDLE)
		else $error("readout continued past last field");
`endif

endmodule

// ----- hw/rtl/boiler_frame_sync_extractor.sv -----
// Top level of the boiler frame sync extractor.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  cfg      | cfg_valid / cfg_ready    | cfg_index[1:0], cfg_data[7:0]
//  input    | in_valid / in_ready      | rx_byte[7:0]
//  output   | out_valid / out_ready    | field_id[3:0], field_value[31:0],
//           |                          | last_field
//
// One byte per cycle while hunting or reading a frame body.
// Frame end: input stalls for the whole readout: a fallback word read, then for each
// of the 14 fields a read, a result load and an output state that waits on out_ready.
// Each field costs one capture-memory read (single read port, registered read data).
// Reset is asynchronous; the capture memory is not cleared (every word is
// written before it is read). cfg_ready is always high.
module boiler_frame_sync_extractor (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] rx_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic [3:0] field_id,
	output logic [31:0] field_value,
	output logic last_field
);

	bfse_pkg::cap_wr_t wr;
	logic frame_done;
	logic busy;
	logic [bfse_pkg::SLOT_W-1:0] rd_addr;
	logic [31:0] rd_data;

	assign cfg_ready = 1'b1;

	bfse_sync u_sync (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.busy       (busy),
		.wr         (wr),
		.frame_done (frame_done)
	);

	bfse_capture_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bfse_readout u_readout (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_done  (frame_done),
		.busy        (busy),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.field_id    (field_id),
		.field_value (field_value),
		.last_field  (last_field)
	);

endmodule

// ----- verif/boiler_frame_sync_extractor_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the frame sync extractor: tracks header hunt and frame capture, checks readout.
module boiler_frame_sync_extractor_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [7:0] rx_byte,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [3:0] field_id,
	input  logic [31:0] field_value,
	input  logic last_field,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, SEEK_THIRD, IN_BODY} hunt_t;

	typedef enum logic [3:0] {
		FLD_BOILER, FLD_FEEDER, FLD_RETURN, FLD_FLAME, FLD_FUEL_RATE, FLD_FAN, FLD_POWER,
		FLD_WORK_FULL, FLD_WORK_HALF, FLD_WORK_THIRD, FLD_WORK_FEEDER, FLD_BURNED,
		FLD_IGNITIONS, FLD_MOTOR_LOCK
	} field_t;

	typedef struct packed {
		logic [3:0] id;
		logic [31:0] value;
		logic last;
	} field_rec_t;

	// capture word slots, in frame offset order
	localparam int W_BOILER = 0;
	localparam int W_FEEDER = 1;
	localparam int W_RETURN_ALT = 2;
	localparam int W_RETURN = 3;
	localparam int W_FLAME = 4;
	localparam int W_FUEL = 5;
	localparam int W_POWER = 6;
	localparam int W_FAN = 7;
	localparam int W_WORK_FULL = 8;
	localparam int W_BURNED = 12;
	localparam int W_IGNITIONS = 13;
	localparam int W_MOTOR_LOCK = 14;
	localparam int NUM_WORDS = 15;
	localparam int NUM_FIELDS = 14;

	localparam logic [7:0] F32_EXP_ONES = 8'hFF;
	localparam logic [30:0] F32_MAG_50 = 31'h4248_0000;
	localparam logic [31:0] F32_PLUS_200 = 32'h4348_0000;

	hunt_t hunt;
	int nbytes;
	logic [7:0] hdr_first, hdr_second, hdr_third;
	logic [31:0] words [NUM_WORDS];
	field_rec_t expected_fields [$];
	field_rec_t rec, want;
	int slot, lane;

	// maps a frame offset to the capture word it feeds, -1 if none
	function automatic int slot_at(input int pos, output int byte_lane);
		byte_lane = 0;
		if (pos >= 86 && pos < 98) begin
			byte_lane = (pos - 86) % 4;
			return W_BOILER + (pos - 86) / 4;
		end
		if (pos >= 106 && pos < 110) begin
			byte_lane = pos - 106;
			return W_RETURN;
		end
		if (pos >= 118 && pos < 122) begin
			byte_lane = pos - 118;
			return W_FLAME;
		end
		if (pos >= 234 && pos < 238) begin
			byte_lane = pos - 234;
			return W_FUEL;
		end
		if (pos >= 250 && pos < 254) begin
			byte_lane = pos - 250;
			return W_POWER;
		end
		if (pos == 279)
			return W_FAN;
		if (pos >= 294 && pos < 302) begin
			byte_lane = (pos - 294) % 2;
			return W_WORK_FULL + (pos - 294) / 2;
		end
		if (pos >= 302 && pos < 306) begin
			byte_lane = pos - 302;
			return W_BURNED;
		end
		if (pos >= 306 && pos < 308) begin
			byte_lane = pos - 306;
			return W_IGNITIONS;
		end
		if (pos >= 310 && pos < 312) begin
			byte_lane = pos - 310;
			return W_MOTOR_LOCK;
		end
		return -1;
	endfunction

	function automatic logic not_finite(input logic [31:0] w);
		return w[30:23] == F32_EXP_ONES;
	endfunction

	// finite and strictly inside (-50, 200); negative zero passes
	function automatic logic alt_usable(input logic [31:0] w);
		if (not_finite(w))
			return 1'b0;
		if (w[31])
			return w[30:0] < F32_MAG_50;
		return w < F32_PLUS_200;
	endfunction

	function automatic logic [31:0] field_word(input field_t f);
		case (f)
			FLD_BOILER: return words[W_BOILER];
			FLD_FEEDER: return words[W_FEEDER];
			FLD_RETURN: begin
				if (not_finite(words[W_RETURN]) && alt_usable(words[W_RETURN_ALT]))
					return words[W_RETURN_ALT];
				return words[W_RETURN];
			end
			FLD_FLAME: return words[W_FLAME];
			FLD_FUEL_RATE: return words[W_FUEL];
			FLD_FAN: return words[W_FAN];
			FLD_POWER: return words[W_POWER];
			FLD_WORK_FULL, FLD_WORK_HALF, FLD_WORK_THIRD, FLD_WORK_FEEDER:
				return words[W_WORK_FULL + (f - FLD_WORK_FULL)];
			FLD_BURNED: return words[W_BURNED];
			FLD_IGNITIONS: return words[W_IGNITIONS];
			default: return words[W_MOTOR_LOCK];
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt = SEEK_FIRST;
			nbytes = 0;
			hdr_first = '0;
			hdr_second = '0;
			hdr_third = '0;
			for (int i = 0; i < NUM_WORDS; i++)
				words[i] = '0;
			expected_fields.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bfse_pkg::REG_HEADER_FIRST: hdr_first = cfg_data;
					bfse_pkg::REG_HEADER_SECOND: hdr_second = cfg_data;
					bfse_pkg::REG_HEADER_THIRD: hdr_third = cfg_data;
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				case (hunt)
					SEEK_FIRST: begin
						if (rx_byte == hdr_first) begin
							hunt = SEEK_SECOND;
							nbytes = 1;
						end
					end
					SEEK_SECOND: begin
						if (rx_byte == hdr_second) begin
							hunt = SEEK_THIRD;
							nbytes = 2;
						end else begin
							hunt = SEEK_FIRST;
							nbytes = 0;
						end
					end
					SEEK_THIRD: begin
						if (rx_byte == hdr_third) begin
							hunt = IN_BODY;
							nbytes = 3;
						end else begin
							hunt = SEEK_FIRST;
							nbytes = 0;
						end
					end
					default: begin
						slot = slot_at(nbytes, lane);
						if (slot >= 0)
							words[slot][8*lane +: 8] = rx_byte;
						nbytes++;
						if (nbytes == bfse_pkg::FRAME_LENGTH) begin
							for (int f = 0; f < NUM_FIELDS; f++) begin
								rec.id = f[3:0];
								rec.value = field_word(field_t'(f));
								rec.last = (f == FLD_MOTOR_LOCK);
								expected_fields.push_back(rec);
							end
							hunt = SEEK_FIRST;
							nbytes = 0;
						end
					end
				endcase
			end

			if (out_valid && out_ready) begin
				if (expected_fields.size() == 0) begin
					$error("field_id %0d arrived with nothing expected", field_id);
					mismatches++;
				end else begin
					want = expected_fields.pop_front();
					if (field_id !== want.id) begin
						$error("field_id: expected %0d, got %0d", want.id, field_id);
						mismatches++;
					end
					if (field_value !== want.value) begin
						$error("field_value: expected %h, got %h", want.value, field_value);
						mismatches++;
					end
					if (last_field !== want.last) begin
						$error("last_field: expected %0d, got %0d", want.last, last_field);
						mismatches++;
					end
				end
			end
			outstanding = expected_fields.size();
		end
	end

endmodule

// ----- verif/boiler_frame_sync_extractor_tb.sv -----
`timescale 1ns / 1ps
// Top of the frame sync extractor testbench: clock, reset, byte stream, readout backpressure.
module boiler_frame_sync_extractor_tb;

	typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int RETURN_OFS = 106;
	localparam int RETURN_ALT_OFS = 94;
	localparam int FIELDS_PER_FRAME = 14;
	localparam int HOLD_AT_FIELD = 6 * FIELDS_PER_FRAME;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = bfse_pkg::REG_HEADER_FIRST;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] field_id;
	logic [31:0] field_value;
	logic last_field;

	int unsigned mismatches;
	int unsigned outstanding;
	logic [7:0] hdr [3];
	logic burst = 1'b0;

	boiler_frame_sync_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.field_id(field_id),
		.field_value(field_value),
		.last_field(last_field)
	);

	boiler_frame_sync_extractor_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.field_id(field_id),
		.field_value(field_value),
		.last_field(last_field),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#10_000_000;
		$display("boiler_frame_sync_extractor regression: fail");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			@(negedge clk) in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (!in_ready);
	endtask

	// drops valid, then lets the readout drain before any register write
	task automatic wait_idle();
		@(negedge clk) in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid = 1'b0;
	endtask

	task automatic set_header(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		wait_idle();
		write_reg(bfse_pkg::REG_HEADER_FIRST, a);
		write_reg(bfse_pkg::REG_HEADER_SECOND, b);
		write_reg(bfse_pkg::REG_HEADER_THIRD, c);
		hdr[0] = a;
		hdr[1] = b;
		hdr[2] = c;
	endtask

	task automatic send_frame(input fill_t fill, input logic [31:0] ret_word,
			input logic [31:0] alt_word);
		logic [7:0] b;
		burst = ($urandom_range(0, 3) == 0);
		send_byte(hdr[0]);
		send_byte(hdr[1]);
		send_byte(hdr[2]);
		for (int pos = 3; pos < bfse_pkg::FRAME_LENGTH; pos++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default: b = 8'($urandom_range(0, 255));
			endcase
			if (pos >= RETURN_OFS && pos < RETURN_OFS + 4)
				b = ret_word[8*(pos - RETURN_OFS) +: 8];
			if (pos >= RETURN_ALT_OFS && pos < RETURN_ALT_OFS + 4)
				b = alt_word[8*(pos - RETURN_ALT_OFS) +: 8];
			send_byte(b);
		end
	endtask

	// return word biased toward NaN and infinity so the fallback gets exercised
	function automatic logic [31:0] return_temp_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom)};
			2: return {1'($urandom_range(0, 1)), 8'hFF, 23'd0};
			default: return 32'h7FC0_0000;
		endcase
	endfunction

	function automatic logic [31:0] fallback_temp_word();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 32'h4347_FFFF);
			2: return 32'h8000_0000 | $urandom_range(0, 32'h4247_FFFF);
			3: return $urandom_range(32'h4348_0000, 32'h7F7F_FFFF);
			4: return 32'h8000_0000 | $urandom_range(32'h4248_0000, 32'h7FFF_FFFF);
			default: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom)};
		endcase
	endfunction

	// noise never holds the first header byte, so the hunt is back at the start
	// when the real header goes out
	task automatic random_episode();
		int unsigned n_noise;
		logic [7:0] b;
		burst = ($urandom_range(0, 3) == 0);
		n_noise = $urandom_range(0, 24);
		for (int i = 0; i < n_noise; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == hdr[0])
				b = ~b;
			send_byte(b);
		end
		case ($urandom_range(0, 2))
			0: begin
				send_byte(hdr[0]);
				if (hdr[0] != hdr[1] && $urandom_range(0, 1))
					b = hdr[0];
				else
					b = hdr[1] ^ 8'($urandom_range(1, 255));
				send_byte(b);
			end
			1: begin
				send_byte(hdr[0]);
				send_byte(hdr[1]);
				send_byte(hdr[2] ^ 8'($urandom_range(1, 255)));
			end
			default: ;
		endcase
		send_frame(FILL_RANDOM, return_temp_word(), fallback_temp_word());
	endtask

	initial begin : byte_source
		@(posedge arst_n);

		set_header(8'h00, 8'h00, 8'h00);
		write_reg(REG_SPARE, 8'hFF);
		send_byte(8'h5C);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h77);
		send_frame(FILL_RANDOM, 32'h7FC0_0000, 32'h42C8_0000);
		send_frame(FILL_ONES, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_frame(FILL_ZERO, 32'h7F80_0000, 32'h4348_0000);

		set_header(8'hFF, 8'hFF, 8'hFF);
		send_byte(8'hFF);
		send_byte(8'h12);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h13);
		send_frame(FILL_RANDOM, 32'hFF80_0000, 32'h8000_0000);
		send_frame(FILL_RANDOM, 32'h7F80_0001, 32'hC248_0000);

		// a byte that breaks the header must not restart the hunt
		set_header(8'hA5, 8'h5A, 8'hC3);
		send_byte(8'hA5);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'hC3);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'hC3);
		send_frame(FILL_RANDOM, 32'h7FFF_FFFF, 32'hC247_FFFF);
		send_frame(FILL_RANDOM, 32'h3F80_0000, 32'h42C8_0000);
		send_frame(FILL_RANDOM, 32'h7FC0_0000, 32'h4347_FFFF);

		for (int n = 0; n < 8; n++) begin
			if (n % 3 == 0)
				set_header(8'($urandom), 8'($urandom), 8'($urandom));
			random_episode();
		end

		@(negedge clk) in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("boiler_frame_sync_extractor regression: pass");
		else
			$display("boiler_frame_sync_extractor regression: fail");
		$finish;
	end

	initial begin : field_sink
		int unsigned taken;
		int unsigned hold;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == HOLD_AT_FIELD) begin
				// long stall once a readout is pending, which also holds off the input bytes
				@(negedge clk) out_ready = 1'b0;
				do @(posedge clk); while (!out_valid);
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				hold = ((taken / FIELDS_PER_FRAME) % 3 == 1) ? 0 : $urandom_range(0, 17);
				if (hold > 0) begin
					@(negedge clk) out_ready = 1'b0;
					repeat (hold - 1) @(negedge clk);
				end
			end
			@(negedge clk) out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

endmodule
